/* src/uv_sphere_vertex_generator_defines.svh */
// Assertion macros for the UV sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
// implication checked on every edge outside reset
`define UVS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define UVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* src/uvs_pkg.sv */
// Shared types, constants and helper functions for the UV sphere vertex generator
package uvs_pkg;
   localparam int unsigned IDX_W = 9;
   localparam int unsigned RAD_W = 16;
   localparam int unsigned POS_W = 25;
   localparam int unsigned TEX_W = 17;
   localparam int unsigned ANG_W = 18;
   localparam int unsigned CSR_W = 16;

   localparam logic [0:0] CSR_SEGMENT_COUNT = 1'd0;
   localparam logic [0:0] CSR_RADIUS        = 1'd1;

   localparam logic [31:0] Q30_A1 = 32'd1686629713;
   localparam logic [31:0] Q30_A3 = 32'd693598668;
   localparam logic [31:0] Q30_A5 = 32'd85569306;
   localparam logic [31:0] Q30_A7 = 32'd5026995;
   localparam logic [31:0] Q30_A9 = 32'd172272;

   // Per-item context carried along the cell chain
   typedef struct packed {
      logic        valid;
      logic        clamped;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [RAD_W-1:0] radius;
   } ctx_type;
endpackage

/* src/uvs_div_cell.sv */
// One restoring-division cell: resolves one quotient bit for u and v
module uvs_div_cell
   (
      input  logic        clock,
      input  logic [8:0]  cnt_i,
      input  logic [26:0] rem_u_i,
      input  logic [26:0] rem_v_i,
      output logic [26:0] rem_u_o,
      output logic [26:0] rem_v_o
   );
   // remainder field [26:17] (10 bits), dividend/quotient bits [16:0]
   logic [26:0] rem_u_in, rem_v_in;

   function automatic logic [26:0] step(input logic [26:0] r, input logic [8:0] d);
      logic [10:0] trial;
      logic [26:0] sh;
      sh    = {r[25:0], 1'b0};
      trial = {1'b0, sh[26:17]} - {2'b00, d};
      if (!trial[10]) begin
         sh[26:17] = trial[9:0];
         sh[0]     = 1'b1;
      end
      return sh;
   endfunction

   always_comb begin
      rem_u_in = step(rem_u_i, cnt_i);
      rem_v_in = step(rem_v_i, cnt_i);
   end

   always_ff @(posedge clock) begin
      rem_u_o <= rem_u_in;
      rem_v_o <= rem_v_in;
   end
endmodule

/* src/uvs_sine_unit.sv */
// Pipelined quarter-wave sine of an 18-bit turn angle, Horner form, at most one multiply per stage
module uvs_sine_unit
   (
      input  logic        clock,
      input  logic [17:0] angle_i,
      output logic [16:0] mag_o,
      output logic        neg_o
   );
   import uvs_pkg::*;

   localparam int unsigned NST = 6;
   localparam int unsigned NHS = 4;
   logic [16:0] f_ff [NST];
   logic        q2_ff [NST];
   logic [31:0] x2_ff [NHS];
   logic [31:0] t_ff [NST];
   logic [63:0] prod_in [NHS];
   logic [16:0] f_in;
   logic [16:0] mag_in;
   logic [47:0] r_in;

   always_comb begin
      f_in = angle_i[16] ? (17'd65536 - {1'b0, angle_i[15:0]}) : {1'b0, angle_i[15:0]};
   end

   // stage 0 folds and squares
   always_ff @(posedge clock) begin
      f_ff[0]  <= f_in;
      q2_ff[0] <= angle_i[17];
      x2_ff[0] <= 32'(({17'd0, f_in} * {17'd0, f_in}) >> 2);
      t_ff[0]  <= Q30_A9;
   end

   // Horner stages: t = A - (x2*t)>>30
   always_comb begin
      for (int i = 0; i < NHS; i++) prod_in[i] = {32'd0, x2_ff[i]} * {32'd0, t_ff[i]};
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i < NST; i++) begin
         f_ff[i]  <= f_ff[i-1];
         q2_ff[i] <= q2_ff[i-1];
      end
      for (int i = 1; i < NHS; i++) x2_ff[i] <= x2_ff[i-1];
      t_ff[1] <= Q30_A7 - 32'(prod_in[0] >> 30);
      t_ff[2] <= Q30_A5 - 32'(prod_in[1] >> 30);
      t_ff[3] <= Q30_A3 - 32'(prod_in[2] >> 30);
      t_ff[4] <= Q30_A1 - 32'(prod_in[3] >> 30);
      t_ff[5] <= t_ff[4];
   end

   // final f*t product with cap
   always_comb begin
      r_in   = 48'({31'd0, f_ff[5]} * {16'd0, t_ff[5]} >> 30);
      mag_in = (r_in > 48'd65536) ? 17'd65536 : r_in[16:0];
   end

   always_ff @(posedge clock) begin
      mag_o <= mag_in;
      neg_o <= q2_ff[5] && (mag_in != 17'd0);
   end
endmodule

/* src/uv_sphere_vertex_generator.sv */
// Top level of the UV sphere vertex generator
// Usage:
//  Configuration: csr_write_enable with csr_index 0 (segment count) or 1
//  (radius, unsigned Q8.8); other indexes are ignored. Write only when idle.
//  Input: a transaction is accepted at a clock edge with start high and busy
//  low. busy is always low, so one grid point can enter every cycle.
//  Output: rsp_valid marks one cycle carrying the vertex position (signed
//  Q8.16), texture coordinates and clamp flag. The receiver cannot stall.
//  Path: 17 index-division cells, the seven-stage sine pipeline, one
//  product register and the output register, which drives rsp_valid and
//  the response fields.
//  Throughput: one vertex per cycle; the division chain and the sine
//  pipelines each take a new operand every cycle.
//  Reset: clears the valid chain and restores count 25 and radius 1.0;
//  items in flight are dropped.
module uv_sphere_vertex_generator #(
      parameter int unsigned MAX_SEGMENTS = 256
   ) (
      input  logic clock,
      input  logic reset,
      input  logic start,
      output logic busy,
      input  logic [8:0] req_ring_index,
      input  logic [8:0] req_column_index,
      input  logic       csr_write_enable,
      input  logic [0:0] csr_index,
      input  logic [uvs_pkg::CSR_W-1:0] csr_write_data,
      output logic rsp_valid,
      output logic signed [24:0] rsp_pos_x,
      output logic signed [24:0] rsp_pos_y,
      output logic signed [24:0] rsp_pos_z,
      output logic [16:0] rsp_tex_u,
      output logic [16:0] rsp_tex_v,
      output logic        rsp_index_clamped
   );
   import uvs_pkg::*;
`include "uv_sphere_vertex_generator_defines.svh"

   localparam int unsigned NDIV = 17;
   localparam int unsigned SDLY = 7;
   localparam int unsigned LAT  = NDIV + SDLY + 1;
   localparam logic [12:0] MAXS = 13'(MAX_SEGMENTS);

   logic [8:0]  seg_ff, seg_in;
   logic [15:0] rad_ff, rad_in;
   logic [8:0]  cnt, ring_c, col_c;
   logic        clamp;
   logic [26:0] ru [NDIV];
   logic [26:0] rv [NDIV];
   logic [8:0]  cnt_ff [NDIV-1];
   ctx_type     ctx_ff [LAT];
   logic [16:0] u_q, v_q;
   logic [17:0] theta, phi;
   logic [16:0] st, ct, sp, cp;
   logic        nst, nct, nsp, ncp;
   logic [33:0] rcp_ff, rsp_ff;
   logic [16:0] st_ff, ct_ff;
   logic        nx_ff, nz_ff, ny_ff;
   logic [50:0] px_in, pz_in;
   logic [24:0] mx_in, my_in, mz_in;

   assign busy = 1'b0;

   // configuration registers
   always_comb begin
      seg_in = seg_ff;
      rad_in = rad_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SEGMENT_COUNT: seg_in = csr_write_data[8:0];
            CSR_RADIUS:        rad_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= 9'd25;
         rad_ff <= 16'd256;
      end else begin
         seg_ff <= seg_in;
         rad_ff <= rad_in;
      end
   end

   // count limits and index clamping
   always_comb begin
      cnt = (seg_ff == 9'd0) ? 9'd1 : seg_ff;
      if ({4'd0, cnt} > MAXS) cnt = MAXS[8:0];
      clamp  = (req_ring_index > cnt) || (req_column_index > cnt);
      ring_c = (req_ring_index > cnt) ? cnt : req_ring_index;
      col_c  = (req_column_index > cnt) ? cnt : req_column_index;
   end

   // dividend is (idx<<16)+cnt/2, up to 25 bits: preload top 8 bits as remainder
   logic [24:0] du, dv;
   logic [26:0] ru0, rv0;
   always_comb begin
      du  = ({16'd0, col_c} << 16) + 25'(cnt >> 1);
      dv  = ({16'd0, ring_c} << 16) + 25'(cnt >> 1);
      ru0 = {2'b00, du[24:17], du[16:0]};
      rv0 = {2'b00, dv[24:17], dv[16:0]};
   end

   // quotient fits 17 bits, so the top 8 dividend bits are below cnt
   // chain of division cells, one quotient bit per cell
   genvar g;
   generate
      for (g = 0; g < NDIV; g++) begin : g_div
         if (g == 0) begin : g_first
            uvs_div_cell u_cell (
               .clock   (clock),
               .cnt_i   (cnt),
               .rem_u_i (ru0),
               .rem_v_i (rv0),
               .rem_u_o (ru[g]),
               .rem_v_o (rv[g])
            );
         end else begin : g_next
            uvs_div_cell u_cell (
               .clock   (clock),
               .cnt_i   (cnt_ff[g-1]),
               .rem_u_i (ru[g-1]),
               .rem_v_i (rv[g-1]),
               .rem_u_o (ru[g]),
               .rem_v_o (rv[g])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      cnt_ff[0] <= cnt;
      for (int i = 1; i < NDIV - 1; i++) cnt_ff[i] <= cnt_ff[i-1];
   end

   assign u_q   = ru[NDIV-1][16:0];
   assign v_q   = rv[NDIV-1][16:0];
   assign theta = {u_q[15:0], 2'b00};
   assign phi   = 18'(18'd65536 - {v_q, 1'b0});

   uvs_sine_unit u_st (.clock(clock), .angle_i(theta), .mag_o(st), .neg_o(nst));
   uvs_sine_unit u_ct (.clock(clock), .angle_i(18'(theta + 18'd65536)), .mag_o(ct),
                       .neg_o(nct));
   uvs_sine_unit u_sp (.clock(clock), .angle_i(phi), .mag_o(sp), .neg_o(nsp));
   uvs_sine_unit u_cp (.clock(clock), .angle_i(18'(phi + 18'd65536)), .mag_o(cp),
                       .neg_o(ncp));

   // context shift line with valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) ctx_ff[i].valid <= 1'b0;
      end else begin
         ctx_ff[0].valid <= start;
         for (int i = 1; i < LAT; i++) ctx_ff[i].valid <= ctx_ff[i-1].valid;
      end
      ctx_ff[0].clamped <= clamp;
      ctx_ff[0].radius  <= rad_ff;
      ctx_ff[0].tex_u   <= 17'd0;
      ctx_ff[0].tex_v   <= 17'd0;
      for (int i = 1; i < LAT; i++) begin
         ctx_ff[i].clamped <= ctx_ff[i-1].clamped;
         ctx_ff[i].radius  <= ctx_ff[i-1].radius;
         ctx_ff[i].tex_u   <= (i == NDIV) ? u_q : ctx_ff[i-1].tex_u;
         ctx_ff[i].tex_v   <= (i == NDIV) ? 17'(17'd65536 - v_q) : ctx_ff[i-1].tex_v;
      end
   end

   // first product stage: r*cp and r*sp
   always_ff @(posedge clock) begin
      rcp_ff <= {17'd0, ctx_ff[NDIV+SDLY-1].radius} * {17'd0, cp};
      rsp_ff <= {17'd0, ctx_ff[NDIV+SDLY-1].radius} * {17'd0, sp};
      st_ff  <= st;
      ct_ff  <= ct;
      nx_ff  <= ncp != nst;
      nz_ff  <= ncp != nct;
      ny_ff  <= nsp;
   end

   // second product stage and rounding
   always_comb begin
      px_in = {17'd0, rcp_ff} * {34'd0, st_ff};
      pz_in = {17'd0, rcp_ff} * {34'd0, ct_ff};
      mx_in = 25'((px_in + 51'd8388608) >> 24);
      mz_in = 25'((pz_in + 51'd8388608) >> 24);
      my_in = 25'((rsp_ff + 34'd128) >> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= ctx_ff[LAT-1].valid;
      rsp_pos_x <= nx_ff ? -mx_in : mx_in;
      rsp_pos_y <= ny_ff ? -my_in : my_in;
      rsp_pos_z <= nz_ff ? -mz_in : mz_in;
      rsp_tex_u <= ctx_ff[LAT-1].tex_u;
      rsp_tex_v <= ctx_ff[LAT-1].tex_v;
      rsp_index_clamped <= ctx_ff[LAT-1].clamped;
   end

   `UVS_ASSERT_IMPL(a_busy_low, clock, reset, 1'b1, !busy, "busy must stay low")
   `UVS_ASSERT_NEXT(a_valid_chain, clock, reset, ctx_ff[LAT-1].valid, rsp_valid,
                    "result strobe lost")
   `UVS_ASSERT_IMPL(a_tex_range, clock, reset, rsp_valid,
                    rsp_tex_u <= 17'd65536 && rsp_tex_v <= 17'd65536,
                    "texture coordinate out of range")
endmodule
